FILE: hw/rtl/mppc_pkg.sv
// ----------------------------------------------------------------------------
// mppc_pkg
// Shared constants, register map and reset values for the motor PID PWM
// controller.
// ----------------------------------------------------------------------------
package mppc_pkg;

  // Default width of the duty output
  localparam int unsigned DUTY_BITS_DEFAULT = 10;

  // Register map, one 32-bit word per register
  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned ADDR_BITS   = 5;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned INDEX_BITS  = 3;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_DELTA_FLOOR    = 3'd4,
    REG_DEAD_THRESHOLD = 3'd5,
    REG_DEAD_OFFSET    = 3'd6,
    REG_DIR_POLARITY   = 3'd7
  } reg_index_e;

  // Register reset values
  localparam logic [15:0] PROP_GAIN_RST      = 16'd512;
  localparam logic [15:0] INTEG_GAIN_RST     = 16'd51;
  localparam logic [15:0] DERIV_GAIN_RST     = 16'd179;
  localparam logic [7:0]  INTEGRAL_LIMIT_RST = 8'd200;
  localparam logic [7:0]  DELTA_FLOOR_RST    = 8'hF6;  // -10
  localparam logic [7:0]  DEAD_THRESHOLD_RST = 8'd5;
  localparam logic [9:0]  DEAD_OFFSET_RST    = 10'd230;
  localparam logic        DIR_POLARITY_RST   = 1'b0;

  // Saturation bounds of the 16-bit control path
  localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAT_MIN = -16'sh8000;

endpackage

FILE: hw/rtl/motor_pid_pwm_controller.sv
// ----------------------------------------------------------------------------
// motor_pid_pwm_controller
// Pipeline: an accepted word moves through the input, term, product and
// control registers and is then loaded into the output register.
// Throughput: one word per cycle; each stage holds one word and moves on when
// the stage after it has room, so only a stalled output holds the pipeline.
// Reset: asynchronous, active low; clears all stage valid bits, the integral,
// previous error, derivative and direction, and loads the register defaults.
// ----------------------------------------------------------------------------
module motor_pid_pwm_controller #(
  parameter int unsigned DUTY_BITS = mppc_pkg::DUTY_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mppc_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [mppc_pkg::DATA_BITS-1:0]     pwdata,
  output logic [mppc_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [15:0]                 target_pos_i,
  input  logic signed [15:0]                 measured_pos_i,
  input  logic [9:0]                         duty_limit_i,
  input  logic                               update_due_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [DUTY_BITS-1:0]               duty_o,
  output logic                               direction_o
);

  localparam logic [16:0] DutyMax = 17'((1 << DUTY_BITS) - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [7:0]  int_limit_q, delta_floor_q, dead_thr_q;
  logic [9:0]  dead_off_q;
  logic        dir_pol_q;
  logic        cfg_wr;
  mppc_pkg::reg_index_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = mppc_pkg::reg_index_e'(paddr[mppc_pkg::INDEX_BITS+1:2]);

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= mppc_pkg::PROP_GAIN_RST;
      integ_gain_q  <= mppc_pkg::INTEG_GAIN_RST;
      deriv_gain_q  <= mppc_pkg::DERIV_GAIN_RST;
      int_limit_q   <= mppc_pkg::INTEGRAL_LIMIT_RST;
      delta_floor_q <= mppc_pkg::DELTA_FLOOR_RST;
      dead_thr_q    <= mppc_pkg::DEAD_THRESHOLD_RST;
      dead_off_q    <= mppc_pkg::DEAD_OFFSET_RST;
      dir_pol_q     <= mppc_pkg::DIR_POLARITY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mppc_pkg::REG_PROP_GAIN:      prop_gain_q   <= pwdata[15:0];
        mppc_pkg::REG_INTEG_GAIN:     integ_gain_q  <= pwdata[15:0];
        mppc_pkg::REG_DERIV_GAIN:     deriv_gain_q  <= pwdata[15:0];
        mppc_pkg::REG_INTEGRAL_LIMIT: int_limit_q   <= pwdata[7:0];
        mppc_pkg::REG_DELTA_FLOOR:    delta_floor_q <= pwdata[7:0];
        mppc_pkg::REG_DEAD_THRESHOLD: dead_thr_q    <= pwdata[7:0];
        mppc_pkg::REG_DEAD_OFFSET:    dead_off_q    <= pwdata[9:0];
        mppc_pkg::REG_DIR_POLARITY:   dir_pol_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      mppc_pkg::REG_PROP_GAIN:      prdata = {16'd0, prop_gain_q};
      mppc_pkg::REG_INTEG_GAIN:     prdata = {16'd0, integ_gain_q};
      mppc_pkg::REG_DERIV_GAIN:     prdata = {16'd0, deriv_gain_q};
      mppc_pkg::REG_INTEGRAL_LIMIT: prdata = {24'd0, int_limit_q};
      mppc_pkg::REG_DELTA_FLOOR:    prdata = {24'd0, delta_floor_q};
      mppc_pkg::REG_DEAD_THRESHOLD: prdata = {24'd0, dead_thr_q};
      mppc_pkg::REG_DEAD_OFFSET:    prdata = {22'd0, dead_off_q};
      mppc_pkg::REG_DIR_POLARITY:   prdata = {31'd0, dir_pol_q};
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_fire, s1_fire, s2_fire, s3_fire, s4_fire;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign s4_rdy  = !s4_v_q || out_rdy;
  assign s3_rdy  = !s3_v_q || s4_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;

  assign in_fire = in_valid_i && s1_rdy;
  assign s1_fire = s1_v_q && s2_rdy;
  assign s2_fire = s2_v_q && s3_rdy;
  assign s3_fire = s3_v_q && s4_rdy;
  assign s4_fire = s4_v_q && out_rdy;

  assign in_stall_o  = !s1_rdy;
  assign out_valid_o = out_v_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_fire)      s1_v_q <= 1'b1;
      else if (s1_fire) s1_v_q <= 1'b0;
      if (s1_fire)      s2_v_q <= 1'b1;
      else if (s2_fire) s2_v_q <= 1'b0;
      if (s2_fire)      s3_v_q <= 1'b1;
      else if (s3_fire) s3_v_q <= 1'b0;
      if (s3_fire)      s4_v_q <= 1'b1;
      else if (s4_fire) s4_v_q <= 1'b0;
      if (s4_fire)      out_v_q <= 1'b1;
      else if (out_rdy) out_v_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic signed [15:0] s1_tgt_q, s1_meas_q;
  logic [9:0]         s1_lim_q;
  logic               s1_upd_q;

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_tgt_q  <= target_pos_i;
      s1_meas_q <= measured_pos_i;
      s1_lim_q  <= duty_limit_i;
      s1_upd_q  <= update_due_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 -> 2: error, derivative and clamped integral
  // --------------------------------------------------------------------------
  logic signed [8:0]  integ_q;
  logic signed [15:0] prev_err_q, deriv_q;
  logic signed [16:0] err_diff, der_diff;
  logic signed [15:0] err, der_new;
  logic signed [17:0] acc_sum, acc_sel, lim_pos, lim_neg, acc_clamp;
  logic signed [8:0]  integ_new;
  logic               der_above;

  // Saturate a 17-bit difference to 16 bits
  function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'(mppc_pkg::SAT_MAX))      r = mppc_pkg::SAT_MAX;
    else if (v < 17'(mppc_pkg::SAT_MIN)) r = mppc_pkg::SAT_MIN;
    else                                 r = v[15:0];
    return r;
  endfunction

  always_comb begin
    err_diff  = 17'(s1_tgt_q) - 17'(s1_meas_q);
    err       = sat17(err_diff);
    der_diff  = 17'(err) - 17'(prev_err_q);
    der_new   = sat17(der_diff);
    der_above = der_new > 16'(signed'(delta_floor_q));
    acc_sum   = 18'(integ_q) + 18'(err);
    acc_sel   = der_above ? acc_sum : 18'(integ_q);
    lim_pos   = signed'({10'd0, int_limit_q});
    lim_neg   = -lim_pos;
    // Clamp to the symmetric limit on every update
    if (acc_sel > lim_pos)      acc_clamp = lim_pos;
    else if (acc_sel < lim_neg) acc_clamp = lim_neg;
    else                        acc_clamp = acc_sel;
    integ_new = acc_clamp[8:0];
  end

  // Update the controller state on update words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
      deriv_q    <= '0;
    end else if (s1_fire && s1_upd_q) begin
      integ_q    <= integ_new;
      prev_err_q <= err;
      deriv_q    <= der_new;
    end
  end

  logic signed [15:0] s2_err_q, s2_der_q;
  logic signed [8:0]  s2_integ_q;
  logic [9:0]         s2_lim_q;

  // Hold the terms seen by this word
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_err_q   <= err;
      s2_integ_q <= s1_upd_q ? integ_new : integ_q;
      s2_der_q   <= s1_upd_q ? der_new : deriv_q;
      s2_lim_q   <= s1_lim_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 -> 3: gain products
  // --------------------------------------------------------------------------
  logic signed [32:0] p_prop, p_der, s3_prop_q, s3_der_q;
  logic signed [25:0] p_int, s3_int_q;
  logic [9:0]         s3_lim_q;

  assign p_prop = $signed({1'b0, prop_gain_q}) * s2_err_q;
  assign p_int  = $signed({1'b0, integ_gain_q}) * s2_integ_q;
  assign p_der  = $signed({1'b0, deriv_gain_q}) * s2_der_q;

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      s3_prop_q <= p_prop;
      s3_int_q  <= p_int;
      s3_der_q  <= p_der;
      s3_lim_q  <= s2_lim_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 -> 4: sum, drop the Q8.8 fraction toward zero, saturate
  // --------------------------------------------------------------------------
  logic signed [34:0] pid_sum, pid_bias;
  logic signed [26:0] pid_quo;
  logic signed [15:0] ctl, s4_ctl_q;
  logic [9:0]         s4_lim_q;

  always_comb begin
    pid_sum  = 35'(s3_prop_q) + 35'(s3_int_q) + 35'(s3_der_q);
    // Bias negative sums so the shift truncates toward zero
    pid_bias = pid_sum + (pid_sum[34] ? 35'sd255 : 35'sd0);
    pid_quo  = 27'(pid_bias >>> 8);
    if (pid_quo > 27'(mppc_pkg::SAT_MAX))      ctl = mppc_pkg::SAT_MAX;
    else if (pid_quo < 27'(mppc_pkg::SAT_MIN)) ctl = mppc_pkg::SAT_MIN;
    else                                       ctl = pid_quo[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (s3_fire) begin
      s4_ctl_q <= ctl;
      s4_lim_q <= s3_lim_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4 -> output: direction, dead band, duty caps
  // --------------------------------------------------------------------------
  logic [16:0]          mag, mag_off, mag_lim, mag_cap;
  logic                 dir_d, dir_q;
  logic [DUTY_BITS-1:0] duty_q;

  always_comb begin
    // Keep the direction when the control value is zero
    if (s4_ctl_q[15])            dir_d = ~dir_pol_q;
    else if (s4_ctl_q != 16'sd0) dir_d = dir_pol_q;
    else                         dir_d = dir_q;
    mag     = s4_ctl_q[15] ? 17'(-17'(s4_ctl_q)) : {1'b0, s4_ctl_q};
    mag_off = (mag > {9'd0, dead_thr_q}) ? mag + {7'd0, dead_off_q} : mag;
    mag_lim = (mag_off > {7'd0, s4_lim_q}) ? {7'd0, s4_lim_q} : mag_off;
    mag_cap = (mag_lim > DutyMax) ? DutyMax : mag_lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (s4_fire) begin
      dir_q <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_fire) begin
      duty_q <= mag_cap[DUTY_BITS-1:0];
    end
  end

  assign duty_o      = duty_q;
  assign direction_o = dir_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An empty input stage never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with empty input stage");

  // After an update word the integral lies within the limit
  a_integ_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_upd_q) |=>
      (integ_q <= signed'({1'b0, int_limit_q}) &&
       integ_q >= -signed'({1'b0, int_limit_q})))
    else $error("integral outside its limit after update");

  // A zero control value keeps the direction
  a_dir_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_fire && s4_ctl_q == 16'sd0) |=> $stable(dir_q))
    else $error("direction changed on zero control value");

  // A loaded duty never exceeds that word's limit
  a_duty_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_fire |=> (17'(duty_o) <= {7'd0, $past(s4_lim_q)}))
    else $error("duty above the duty limit");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor PID PWM controller. A driver process
// offers position words from a queue, and a predictor computes the expected
// duty and direction of each accepted word. A monitor process compares each
// result with the oldest expectation. Gain settings change between phases
// while the block is idle. Both sides insert random gaps, except in one
// back-to-back phase; the receiver holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DUTY_W          = mppc_pkg::DUTY_BITS_DEFAULT;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned WORDS_PER_PHASE = 290;
  localparam int unsigned LONG_HOLD_LEN   = 120;

  typedef struct {
    logic signed [15:0] target;
    logic signed [15:0] measured;
    logic [9:0]         limit;
    logic               upd;
  } pos_word_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              dir;
  } drive_t;

  typedef struct {
    logic [15:0]       kp;
    logic [15:0]       ki;
    logic [15:0]       kd;
    logic [7:0]        ilim;
    logic signed [7:0] dfloor;
    logic [7:0]        dthr;
    logic [9:0]        doff;
    logic              pol;
  } gain_set_t;

  // DUT connections
  logic                           clk_i;
  logic                           rst_ni         = 1'b0;
  logic                           psel           = 1'b0;
  logic                           penable        = 1'b0;
  logic                           pwrite         = 1'b0;
  logic [mppc_pkg::ADDR_BITS-1:0] paddr          = '0;
  logic [mppc_pkg::DATA_BITS-1:0] pwdata         = '0;
  logic [mppc_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;
  logic                           in_valid_i     = 1'b0;
  logic                           in_stall_o;
  logic signed [15:0]             target_pos_i   = '0;
  logic signed [15:0]             measured_pos_i = '0;
  logic [9:0]                     duty_limit_i   = '0;
  logic                           update_due_i   = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i    = 1'b0;
  logic [DUTY_W-1:0]              duty_o;
  logic                           direction_o;

  // Predictor copy of the registers and loop state
  logic [15:0]        kp_q, ki_q, kd_q;
  logic [7:0]         ilim_q, dthr_q;
  logic signed [7:0]  dfloor_q;
  logic [9:0]         doff_q;
  logic               pol_q;
  logic signed [8:0]  integ_q;
  logic signed [15:0] prev_err_q, deriv_q;
  logic               dir_q;

  // Word and result bookkeeping
  pos_word_t   word_q[$];
  drive_t      duty_expect_q[$];
  pos_word_t   cur_word;
  drive_t      predicted_drive, expected_drive;
  gain_set_t   phase_gains;
  logic        offer_next;
  logic        idle_en = 1'b1;
  int unsigned send_gap, stall_left, quiet_cycles;
  int unsigned words_sent, results_seen, settings_used, errors;
  int unsigned long_hold_at = 400;

  motor_pid_pwm_controller #(.DUTY_BITS(DUTY_W)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .target_pos_i   (target_pos_i),
    .measured_pos_i (measured_pos_i),
    .duty_limit_i   (duty_limit_i),
    .update_due_i   (update_due_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .duty_o         (duty_o),
    .direction_o    (direction_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'sh0000;
      3: return -16'sh0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(0, 64));
      1: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic gain_set_t rand_gain_set();
    gain_set_t g;
    g.kp     = rand_gain();
    g.ki     = rand_gain();
    g.kd     = rand_gain();
    g.ilim   = 8'($urandom);
    g.dfloor = 8'($urandom);
    g.dthr   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
    g.doff   = 10'($urandom);
    g.pol    = 1'($urandom);
    return g;
  endfunction

  // Compute duty and direction for one word; advance the loop state
  task automatic pid_step(input pos_word_t w, output drive_t res);
    longint err, acc, sum, ctl, mag;
    err = sat16(longint'(w.target) - longint'(w.measured));
    if (w.upd) begin
      deriv_q = 16'(sat16(err - longint'(prev_err_q)));
      acc = longint'(integ_q);
      if (longint'(deriv_q) > longint'(dfloor_q)) acc += err;
      // clamp on every update, even when nothing was added
      if (acc > longint'(ilim_q)) acc = longint'(ilim_q);
      if (acc < -longint'(ilim_q)) acc = -longint'(ilim_q);
      integ_q    = 9'(acc);
      prev_err_q = 16'(err);
    end
    sum = longint'(kp_q) * err + longint'(ki_q) * longint'(integ_q)
        + longint'(kd_q) * longint'(deriv_q);
    // signed division truncates toward zero
    ctl = sat16(sum / 256);
    if (ctl > 0) dir_q = pol_q;
    else if (ctl < 0) dir_q = ~pol_q;
    mag = (ctl < 0) ? -ctl : ctl;
    if (mag > longint'(dthr_q)) mag += longint'(doff_q);
    if (mag > longint'(w.limit)) mag = longint'(w.limit);
    if (mag > longint'((1 << DUTY_W) - 1)) mag = longint'((1 << DUTY_W) - 1);
    res.duty = DUTY_W'(mag);
    res.dir  = dir_q;
  endtask

  // Write one register: setup, then access, then idle
  task automatic write_reg(input mppc_pkg::reg_index_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mppc_pkg::REG_PROP_GAIN:      kp_q     = val[15:0];
      mppc_pkg::REG_INTEG_GAIN:     ki_q     = val[15:0];
      mppc_pkg::REG_DERIV_GAIN:     kd_q     = val[15:0];
      mppc_pkg::REG_INTEGRAL_LIMIT: ilim_q   = val[7:0];
      mppc_pkg::REG_DELTA_FLOOR:    dfloor_q = val[7:0];
      mppc_pkg::REG_DEAD_THRESHOLD: dthr_q   = val[7:0];
      mppc_pkg::REG_DEAD_OFFSET:    doff_q   = val[9:0];
      mppc_pkg::REG_DIR_POLARITY:   pol_q    = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_gains(input gain_set_t g);
    write_reg(mppc_pkg::REG_PROP_GAIN, 32'(g.kp));
    write_reg(mppc_pkg::REG_INTEG_GAIN, 32'(g.ki));
    write_reg(mppc_pkg::REG_DERIV_GAIN, 32'(g.kd));
    write_reg(mppc_pkg::REG_INTEGRAL_LIMIT, 32'(g.ilim));
    write_reg(mppc_pkg::REG_DELTA_FLOOR, 32'(8'(g.dfloor)));
    write_reg(mppc_pkg::REG_DEAD_THRESHOLD, 32'(g.dthr));
    write_reg(mppc_pkg::REG_DEAD_OFFSET, 32'(g.doff));
    write_reg(mppc_pkg::REG_DIR_POLARITY, 32'(g.pol));
    settings_used++;
  endtask

  task automatic queue_word(input logic signed [15:0] tgt, input logic signed [15:0] meas,
                            input logic [9:0] lim, input logic upd);
    pos_word_t w;
    w.target   = tgt;
    w.measured = meas;
    w.limit    = lim;
    w.upd      = upd;
    word_q.push_back(w);
  endtask

  // Hold until every queued word is sent and every result is back;
  // sample on the falling edge so the clocked processes have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || duty_expect_q.size() != 0)
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned queued, mode;
    longint      tgt_l, pos_l;
    logic [9:0]  lim;
    queued = 0;
    while (queued < n) begin
      mode = $urandom_range(0, 99);
      lim = ($urandom_range(0, 9) < 2) ? 10'd1023 :
            ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom);
      if (mode < 20 && n - queued >= 8) begin
        // track a target: position closes in, slow update every other word
        tgt_l = longint'($urandom_range(0, 40000)) - 20000;
        pos_l = tgt_l + longint'($urandom_range(0, 2000)) - 1000;
        for (int k = 0; k < 8; k++) begin
          queue_word(16'(tgt_l), 16'(pos_l), lim, k[0]);
          pos_l = (pos_l + tgt_l) / 2;
        end
        queued += 8;
      end else begin
        if (mode < 50) begin
          pos_l = longint'($urandom_range(0, 65535));
          tgt_l = pos_l + longint'($urandom_range(0, 80)) - 40;
        end else if (mode < 65) begin
          pos_l = longint'($urandom_range(0, 65535));
          tgt_l = pos_l + longint'($urandom_range(0, 1200)) - 600;
        end else if (mode < 88) begin
          pos_l = longint'($urandom_range(0, 65535));
          tgt_l = longint'($urandom_range(0, 65535));
        end else begin
          pos_l = longint'(pick_extreme());
          tgt_l = longint'(pick_extreme());
        end
        queue_word(16'(tgt_l), 16'(pos_l), lim, 1'($urandom));
        queued++;
      end
    end
  endtask

  // Driver: offer queued words, predict each one as it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer_next = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        pid_step(cur_word, predicted_drive);
        duty_expect_q.push_back(predicted_drive);
        words_sent++;
        offer_next = 1'b0;
        if (idle_en && $urandom_range(0, 2) == 0) send_gap = pick_len();
      end
      if (!offer_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          target_pos_i   <= cur_word.target;
          measured_pos_i <= cur_word.measured;
          duty_limit_i   <= cur_word.limit;
          update_due_i   <= cur_word.upd;
          offer_next = 1'b1;
        end
      end
      in_valid_i <= offer_next;
    end
  end

  // Monitor: check each accepted result, then pick the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (duty_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got duty %0d direction %0d",
                   $time, duty_o, direction_o);
          errors++;
        end else begin
          expected_drive = duty_expect_q.pop_front();
          if (duty_o !== expected_drive.duty) begin
            $display("%0t: duty mismatch, expected %0d, got %0d",
                     $time, expected_drive.duty, duty_o);
            errors++;
          end
          if (direction_o !== expected_drive.dir) begin
            $display("%0t: direction mismatch, expected %0d, got %0d",
                     $time, expected_drive.dir, direction_o);
            errors++;
          end
        end
      end
      // hold off for a long stretch now and then so the pipeline backs up
      if (results_seen >= long_hold_at) begin
        long_hold_at += 700;
        stall_left = LONG_HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    kp_q       = mppc_pkg::PROP_GAIN_RST;
    ki_q       = mppc_pkg::INTEG_GAIN_RST;
    kd_q       = mppc_pkg::DERIV_GAIN_RST;
    ilim_q     = mppc_pkg::INTEGRAL_LIMIT_RST;
    dfloor_q   = mppc_pkg::DELTA_FLOOR_RST;
    dthr_q     = mppc_pkg::DEAD_THRESHOLD_RST;
    doff_q     = mppc_pkg::DEAD_OFFSET_RST;
    pol_q      = mppc_pkg::DIR_POLARITY_RST;
    integ_q    = '0;
    prev_err_q = '0;
    deriv_q    = '0;
    dir_q      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains: zero control, saturating errors, derivative swing
    queue_word(16'sd0, 16'sd0, 10'd1023, 1'b0);
    queue_word(16'sh7FFF, -16'sh8000, 10'd1023, 1'b1);
    queue_word(-16'sh8000, 16'sh7FFF, 10'd1023, 1'b1);
    queue_word(-16'sh8000, 16'sh7FFF, 10'd0, 1'b0);
    queue_word(16'sh5555, 16'shAAAA, 10'h2AA, 1'b1);
    queue_word(16'shAAAA, 16'sh5555, 10'h155, 1'b0);
    queue_word(16'sd100, 16'sd0, 10'd1023, 1'b1);
    queue_word(16'sd100, 16'sd0, 10'd1023, 1'b1);
    // derivative below the floor: no integration
    queue_word(16'sd0, 16'sd100, 10'd512, 1'b1);
    queue_word(-16'sd1, 16'sd0, 10'd1023, 1'b0);
    wait_idle();

    // Unity gain: dead band edges, inverted direction, hold on zero, caps
    apply_gains('{16'd256, 16'd0, 16'd0, 8'd255, -8'sd128, 8'd5, 10'd230, 1'b1});
    queue_word(16'sd5, 16'sd0, 10'd1023, 1'b0);
    queue_word(16'sd6, 16'sd0, 10'd1023, 1'b0);
    queue_word(-16'sd6, 16'sd0, 10'd1023, 1'b0);
    queue_word(16'sd0, 16'sd0, 10'd1023, 1'b0);
    queue_word(16'sd1000, 16'sd0, 10'd700, 1'b1);
    queue_word(-16'sh8000, 16'sh7FFF, 10'd1023, 1'b0);
    wait_idle();

    // Zero threshold: zero control still gives no offset
    apply_gains('{16'd256, 16'd0, 16'd0, 8'd255, -8'sd128, 8'd0, 10'd1023, 1'b0});
    queue_word(16'sd0, 16'sd0, 10'd1023, 1'b0);
    queue_word(16'sd1, 16'sd0, 10'd1023, 1'b0);
    queue_word(16'sd0, 16'sd1, 10'd500, 1'b0);
    wait_idle();

    // Integral only: fill up, then shrink the limit
    apply_gains('{16'd0, 16'd256, 16'd0, 8'd255, -8'sd128, 8'd255, 10'd0, 1'b0});
    queue_word(16'sd200, 16'sd0, 10'd1023, 1'b1);
    queue_word(16'sd100, 16'sd0, 10'd1023, 1'b1);
    queue_word(16'sd0, 16'sd0, 10'd1023, 1'b0);
    wait_idle();
    write_reg(mppc_pkg::REG_INTEGRAL_LIMIT, 32'd10);
    // smaller limit is applied only on the next slow update
    queue_word(16'sd0, 16'sd0, 10'd1023, 1'b0);
    queue_word(16'sd0, 16'sd0, 10'd1023, 1'b1);
    wait_idle();

    // Random phases over several gain settings, extremes among them
    for (int p = 0; p < 6; p++) begin
      case (p)
        1: phase_gains = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'sd127, 8'd255,
                           10'd1023, 1'b1};
        3: phase_gains = '{16'd0, 16'd0, 16'd0, 8'd0, -8'sd128, 8'd0, 10'd0, 1'b0};
        5: phase_gains = '{mppc_pkg::PROP_GAIN_RST, mppc_pkg::INTEG_GAIN_RST,
                           mppc_pkg::DERIV_GAIN_RST, mppc_pkg::INTEGRAL_LIMIT_RST,
                           mppc_pkg::DELTA_FLOOR_RST, mppc_pkg::DEAD_THRESHOLD_RST,
                           mppc_pkg::DEAD_OFFSET_RST, mppc_pkg::DIR_POLARITY_RST};
        default: phase_gains = rand_gain_set();
      endcase
      apply_gains(phase_gains);
      // one phase runs back to back with no random gaps
      idle_en <= (p != 1);
      queue_random(WORDS_PER_PHASE);
      wait_idle();
    end

    repeat (12) @(posedge clk_i);
    if (duty_expect_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, duty_expect_q.size());
      errors++;
    end
    $display("Run sent %0d position words and checked %0d results under %0d gain settings.",
             words_sent, results_seen, settings_used);
    $display("Exercised saturation, dead band, direction hold, integral clamp and back-pressure.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: motor_pid_pwm_controller.f
hw/rtl/mppc_pkg.sv
hw/rtl/motor_pid_pwm_controller.sv
bench/tb_top.sv
